FILE: hw/rtl/bthalloc_pkg.sv
// Shared constants and codes of the boundary tag heap allocator
package bthalloc_pkg;

  // default geometry
  localparam int PAGE_BYTES_DEF = 4096;
  localparam int MAX_PAGES_DEF  = 4;
  localparam int GRANULE_BYTES  = 16;
  localparam int GRAN_SHIFT     = $clog2(GRANULE_BYTES);

  // request kinds
  localparam logic [1:0] K_ALLOC   = 2'd0;
  localparam logic [1:0] K_FREE    = 2'd1;
  localparam logic [1:0] K_REALLOC = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NOMEM   = 2'd2;

endpackage

FILE: hw/rtl/boundary_tag_heap_allocator_unit.sv
// Boundary tag heap allocator: explicit LIFO free list, next-fit search, coalescing free
//
// Each request is handled one at a time by a sequencer around five registered-read
// memories (block tags, end tags, start marks, previous and next links), each with
// one read port and one write port. An allocate walks the free list from the roving
// pointer with next-fit and grows the heap by a page when no block fits. A reallocate
// costs a pointer check, an allocate and a free, or only a free when the new size is
// zero. After reset the start mark memory is cleared one entry per cycle, and no
// request is taken until all GRAN_MAX entries are cleared.
// A finished result sits in the output register while the next request is taken.
module boundary_tag_heap_allocator_unit #(
  parameter int PAGE_BYTES = bthalloc_pkg::PAGE_BYTES_DEF,
  parameter int MAX_PAGES  = bthalloc_pkg::MAX_PAGES_DEF,
  parameter int GRAN_MAX   = MAX_PAGES * (PAGE_BYTES / bthalloc_pkg::GRANULE_BYTES),
  parameter int AW         = $clog2(GRAN_MAX) + bthalloc_pkg::GRAN_SHIFT,
  parameter int PGW        = $clog2(MAX_PAGES + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     kind,
  input  logic [AW-1:0]  address,
  input  logic [15:0]    size,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     status,
  output logic [AW-1:0]  result_address,
  output logic [15:0]    copy_length,
  output logic [PGW-1:0] pages_in_use
);

  localparam int GSH  = bthalloc_pkg::GRAN_SHIFT;
  localparam int GPP  = PAGE_BYTES / bthalloc_pkg::GRANULE_BYTES;
  localparam int GW   = $clog2(GRAN_MAX);
  localparam int PW   = GW + 1;
  localparam int TAGW = 16 + 1 + GW;
  localparam int NW   = 16 - GSH + 1;
  localparam int CW   = ((NW > GW) ? NW : GW) + 1;
  localparam int SBW  = GW + 2;
  localparam int XW   = ((GW + GSH > 16) ? GW + GSH : 16) + 1;
  localparam logic [PW-1:0] NIL = '1;

  // sequencer states
  localparam logic [5:0] S_CLR   = 6'd0;
  localparam logic [5:0] S_IDLE  = 6'd1;
  localparam logic [5:0] S_START = 6'd2;
  localparam logic [5:0] S_C0    = 6'd3;
  localparam logic [5:0] S_C1    = 6'd4;
  localparam logic [5:0] S_A0    = 6'd5;
  localparam logic [5:0] S_A1    = 6'd6;
  localparam logic [5:0] S_AGR   = 6'd7;
  localparam logic [5:0] S_A2    = 6'd8;
  localparam logic [5:0] S_A3    = 6'd9;
  localparam logic [5:0] S_A4    = 6'd10;
  localparam logic [5:0] S_A5    = 6'd11;
  localparam logic [5:0] S_A6    = 6'd12;
  localparam logic [5:0] S_AFA   = 6'd13;
  localparam logic [5:0] S_F0    = 6'd14;
  localparam logic [5:0] S_F1    = 6'd15;
  localparam logic [5:0] S_F2    = 6'd16;
  localparam logic [5:0] S_F3    = 6'd17;
  localparam logic [5:0] S_F4    = 6'd18;
  localparam logic [5:0] S_F5    = 6'd19;
  localparam logic [5:0] S_F6    = 6'd20;
  localparam logic [5:0] S_F7    = 6'd21;
  localparam logic [5:0] S_F8    = 6'd22;
  localparam logic [5:0] S_F9    = 6'd23;
  localparam logic [5:0] S_AFF   = 6'd24;
  localparam logic [5:0] S_G0    = 6'd25;
  localparam logic [5:0] S_G1    = 6'd26;
  localparam logic [5:0] S_G2    = 6'd27;
  localparam logic [5:0] S_P0    = 6'd28;
  localparam logic [5:0] S_P1    = 6'd29;
  localparam logic [5:0] S_U0    = 6'd30;
  localparam logic [5:0] S_U1    = 6'd31;
  localparam logic [5:0] S_FIN   = 6'd32;

  // memories
  logic [TAGW-1:0] tag_mem [GRAN_MAX];
  logic [GW:0]     end_mem [GRAN_MAX];
  logic            sm_mem  [GRAN_MAX];
  logic [PW-1:0]   prv_mem [GRAN_MAX];
  logic [PW-1:0]   nxt_mem [GRAN_MAX];

  logic [TAGW-1:0] tag_rd;
  logic [GW:0]     end_rd;
  logic            sm_rd;
  logic [PW-1:0]   prv_rd;
  logic [PW-1:0]   nxt_rd;

  logic            tag_we, end_we, sm_we, prv_we, nxt_we;
  logic [GW-1:0]   tag_wa, end_wa, sm_wa, prv_wa, nxt_wa;
  logic [TAGW-1:0] tag_wd;
  logic [GW:0]     end_wd;
  logic            sm_wd;
  logic [PW-1:0]   prv_wd, nxt_wd;
  logic [GW-1:0]   tag_ra, end_ra, sm_ra, prv_ra, nxt_ra;

  // sequencer registers
  logic [5:0]     state, grow_ret, push_ret, unlink_ret;
  logic [GW-1:0]  clr_idx;
  logic [1:0]     kind_q;
  logic [AW-1:0]  addr_q;
  logic [15:0]    size_q, old_q, cl_q;
  logic [1:0]     st_q;
  logic [AW-1:0]  ra_q;
  logic [PW-1:0]  head, rov, origin, ncur;
  logic [PGW-1:0] pages;
  logic [GW-1:0]  cur, b_q, nd_q, gx, px, ux, f_s, pstart, nsz, newg;
  logic [GW:0]    gt, nstart;
  logic [SBW-1:0] news;
  logic           grow_ok, pf, nf;

  // derived values
  logic [GW:0]     tot;
  logic [NW-1:0]   need;
  logic [GW-1:0]   rd_sz, e_sz, chk_x, nd, rem, rs;
  logic            rd_al, e_al, fit, split, merge, chk_pre_bad, chk_bad, f_pf;
  logic [15:0]     rd_req;
  logic [PW-1:0]   step;

  // block write helper
  logic            sb_go, sb_al, sb_ok;
  logic [GW-1:0]   sb_g;
  logic [SBW-1:0]  sb_s;
  logic [15:0]     sb_req;

  // usable heap size and request size in granules, decoded tags and pointer, fit, split and merge tests
  always_comb begin
    tot    = (pages == '0) ? '0 : ((GW+1)'(pages) * (GW+1)'(GPP) - (GW+1)'(1));
    need   = NW'(size_q[15:GSH]) + NW'(|size_q[GSH-1:0]) + NW'(1);
    rd_sz  = tag_rd[GW-1:0];
    rd_al  = tag_rd[GW];
    rd_req = tag_rd[TAGW-1:GW+1];
    e_sz   = end_rd[GW-1:0];
    e_al   = end_rd[GW];
    chk_x  = addr_q[AW-1:GSH] - GW'(1);
    chk_pre_bad = (addr_q[AW-1:GSH] == '0) || (addr_q[GSH-1:0] != '0) ||
                  ({1'b0, chk_x} >= tot);
    chk_bad = !sm_rd || !rd_al || (rd_sz == '0) ||
              ((GW+1)'(chk_x) + (GW+1)'(rd_sz) > tot) ||
              (XW'(rd_req) > XW'({rd_sz, {GSH{1'b0}}}));
    fit    = CW'(rd_sz) >= CW'(need);
    step   = (nxt_rd == NIL) ? head : nxt_rd;
    nd     = (CW'(b_q) == CW'(need) + CW'(1)) ? b_q : GW'(need);
    split  = b_q != nd;
    rem    = cur + nd;
    rs     = b_q - nd;
    merge  = !e_al && ((GW+1)'(e_sz) <= gt) && (e_sz != '0);
    f_pf   = (gx != '0) && !e_al && (e_sz != '0) && (e_sz <= gx);
  end

  // block tag writes requested by the sequencer
  always_comb begin
    sb_go  = 1'b0;
    sb_g   = '0;
    sb_s   = '0;
    sb_al  = 1'b0;
    sb_req = '0;
    case (state)
      S_A0: begin
        if (size_q != '0 && pages == '0) begin
          sb_go = 1'b1;
          sb_s  = SBW'(GPP - 1);
        end
      end
      S_A4: begin
        if (split) begin
          sb_go = 1'b1;
          sb_g  = rem;
          sb_s  = SBW'(rs);
        end
      end
      S_A5: begin
        sb_go  = 1'b1;
        sb_g   = cur;
        sb_s   = SBW'(nd_q);
        sb_al  = 1'b1;
        sb_req = size_q;
      end
      S_F5: begin
        sb_go = 1'b1;
        sb_g  = newg;
        sb_s  = news;
      end
      S_G1: begin
        sb_go = 1'b1;
        if (merge) begin
          sb_g = GW'(gt - (GW+1)'(e_sz));
          sb_s = SBW'(e_sz) + SBW'(GPP);
        end else begin
          sb_g = gt[GW-1:0];
          sb_s = SBW'(GPP);
        end
      end
      default: sb_go = 1'b0;
    endcase
    sb_ok = sb_go && (sb_s != '0) && ((SBW'(sb_g) + sb_s) <= SBW'(GRAN_MAX));
  end

  // memory ports
  always_comb begin
    tag_we = sb_ok;
    tag_wa = sb_g;
    tag_wd = {sb_req, sb_al, sb_s[GW-1:0]};
    end_we = sb_ok;
    end_wa = sb_g + sb_s[GW-1:0] - GW'(1);
    end_wd = {sb_al, sb_s[GW-1:0]};
    sm_we  = 1'b0;
    sm_wa  = sb_g;
    sm_wd  = 1'b1;
    prv_we = 1'b0;
    prv_wa = '0;
    prv_wd = NIL;
    nxt_we = 1'b0;
    nxt_wa = '0;
    nxt_wd = NIL;
    tag_ra = '0;
    end_ra = '0;
    sm_ra  = '0;
    prv_ra = '0;
    nxt_ra = '0;
    if (sb_ok) begin
      sm_we = 1'b1;
    end
    case (state)
      S_CLR: begin
        sm_we = 1'b1;
        sm_wa = clr_idx;
        sm_wd = 1'b0;
      end
      S_C0: begin
        tag_ra = chk_x;
        sm_ra  = chk_x;
      end
      S_A0: begin
        if (size_q != '0 && pages == '0) begin
          prv_we = 1'b1;
          nxt_we = 1'b1;
        end
      end
      S_A2: begin
        tag_ra = rov[GW-1:0];
        nxt_ra = rov[GW-1:0];
      end
      S_F0: tag_ra = gx;
      S_F1: begin
        tag_ra = gx + rd_sz;
        end_ra = gx - GW'(1);
      end
      S_F2: tag_ra = gx - e_sz;
      S_F3: begin
        sm_we = pf;
        sm_wa = gx;
        sm_wd = 1'b0;
      end
      S_F4: begin
        sm_we = nf;
        sm_wa = nstart[GW-1:0];
        sm_wd = 1'b0;
      end
      S_F8: begin
        if (head == NIL) begin
          prv_we = 1'b1;
          prv_wa = newg;
          nxt_we = 1'b1;
          nxt_wa = newg;
        end
      end
      S_G0: end_ra = GW'(tot - (GW+1)'(1));
      S_P0: begin
        prv_we = 1'b1;
        prv_wa = px;
        nxt_we = 1'b1;
        nxt_wa = px;
        nxt_wd = head;
      end
      S_P1: begin
        prv_we = head != NIL;
        prv_wa = head[GW-1:0];
        prv_wd = {1'b0, px};
      end
      S_U0: begin
        prv_ra = ux;
        nxt_ra = ux;
      end
      S_U1: begin
        if (prv_rd != NIL) begin
          nxt_we = 1'b1;
          nxt_wa = prv_rd[GW-1:0];
          nxt_wd = nxt_rd;
          prv_we = nxt_rd != NIL;
          prv_wa = nxt_rd[GW-1:0];
          prv_wd = prv_rd;
        end else if (nxt_rd != NIL) begin
          prv_we = 1'b1;
          prv_wa = nxt_rd[GW-1:0];
        end
      end
      default: tag_ra = '0;
    endcase
  end

  // memory arrays
  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[tag_wa] <= tag_wd;
    if (end_we) end_mem[end_wa] <= end_wd;
    if (sm_we) sm_mem[sm_wa] <= sm_wd;
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    tag_rd <= tag_mem[tag_ra];
    end_rd <= end_mem[end_ra];
    sm_rd  <= sm_mem[sm_ra];
    prv_rd <= prv_mem[prv_ra];
    nxt_rd <= nxt_mem[nxt_ra];
  end

  assign in_ready = state == S_IDLE;

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_idx   <= '0;
      head      <= NIL;
      rov       <= NIL;
      pages     <= '0;
      out_valid <= 1'b0;
    end else begin
      // a result handed over in the finish state refills the output register itself
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_idx <= clr_idx + GW'(1);
          if (clr_idx == GW'(GRAN_MAX - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            kind_q <= kind;
            addr_q <= address;
            size_q <= size;
            st_q   <= bthalloc_pkg::ST_INVALID;
            ra_q   <= '0;
            cl_q   <= '0;
            state  <= S_START;
          end
        end
        S_START: begin
          case (kind_q)
            bthalloc_pkg::K_ALLOC:   state <= S_A0;
            bthalloc_pkg::K_FREE:    state <= S_C0;
            bthalloc_pkg::K_REALLOC: state <= S_C0;
            default:                 state <= S_FIN;
          endcase
        end
        // pointer check
        S_C0: state <= chk_pre_bad ? S_FIN : S_C1;
        S_C1: begin
          if (chk_bad) begin
            state <= S_FIN;
          end else begin
            gx    <= chk_x;
            old_q <= rd_req;
            state <= (kind_q == bthalloc_pkg::K_REALLOC && size_q != '0) ? S_A0 : S_F0;
          end
        end
        // allocate: setup and next-fit walk
        S_A0: begin
          if (size_q == '0) begin
            st_q  <= bthalloc_pkg::ST_INVALID;
            state <= S_AFA;
          end else begin
            if (pages == '0) begin
              pages <= PGW'(1);
              head  <= '0;
              rov   <= '0;
            end
            state <= S_A1;
          end
        end
        S_A1: begin
          if (rov == NIL) begin
            grow_ret <= S_AGR;
            state    <= S_G0;
          end else begin
            origin <= rov;
            state  <= S_A2;
          end
        end
        S_AGR: begin
          if (!grow_ok) begin
            st_q  <= bthalloc_pkg::ST_NOMEM;
            state <= S_AFA;
          end else begin
            origin <= rov;
            state  <= S_A2;
          end
        end
        S_A2: state <= S_A3;
        S_A3: begin
          if (fit) begin
            cur   <= rov[GW-1:0];
            b_q   <= rd_sz;
            ncur  <= nxt_rd;
            state <= S_A4;
          end else begin
            rov <= step;
            if (step == origin) begin
              grow_ret <= S_AGR;
              state    <= S_G0;
            end else begin
              state <= S_A2;
            end
          end
        end
        // allocate: split, mark and unlink
        S_A4: begin
          nd_q <= nd;
          if (split) begin
            px       <= rem;
            push_ret <= S_A5;
            state    <= S_P0;
          end else begin
            state <= S_A5;
          end
        end
        S_A5: begin
          rov        <= (ncur == NIL) ? head : ncur;
          ux         <= cur;
          unlink_ret <= S_A6;
          state      <= S_U0;
        end
        S_A6: begin
          ra_q  <= {cur + GW'(1), {GSH{1'b0}}};
          st_q  <= bthalloc_pkg::ST_OK;
          state <= S_AFA;
        end
        S_AFA: begin
          if (kind_q == bthalloc_pkg::K_REALLOC && st_q == bthalloc_pkg::ST_OK) begin
            cl_q  <= (size_q < old_q) ? size_q : old_q;
            state <= S_F0;
          end else begin
            state <= S_FIN;
          end
        end
        // free: look at both neighbors, merge them and push the new block
        S_F0: state <= S_F1;
        S_F1: begin
          f_s    <= rd_sz;
          nstart <= (GW+1)'(gx) + (GW+1)'(rd_sz);
          state  <= S_F2;
        end
        S_F2: begin
          pf     <= f_pf;
          pstart <= gx - e_sz;
          nf     <= (nstart < tot) && !rd_al;
          nsz    <= rd_sz;
          state  <= S_F3;
        end
        S_F3: begin
          news  <= SBW'(f_s) + (pf ? SBW'(rd_sz) : '0) + (nf ? SBW'(nsz) : '0);
          newg  <= pf ? pstart : gx;
          state <= S_F4;
        end
        S_F4: state <= S_F5;
        S_F5: state <= S_F6;
        S_F6: begin
          if (pf) begin
            ux         <= pstart;
            unlink_ret <= S_F7;
            state      <= S_U0;
          end else begin
            state <= S_F7;
          end
        end
        S_F7: begin
          if (nf) begin
            ux         <= nstart[GW-1:0];
            unlink_ret <= S_F8;
            state      <= S_U0;
          end else begin
            state <= S_F8;
          end
        end
        S_F8: begin
          if (head == NIL) begin
            head  <= {1'b0, newg};
            rov   <= {1'b0, newg};
            state <= S_AFF;
          end else begin
            px       <= newg;
            push_ret <= S_F9;
            state    <= S_P0;
          end
        end
        S_F9: begin
          if ((pf && rov == {1'b0, pstart}) || (nf && rov == nstart)) rov <= head;
          state <= S_AFF;
        end
        S_AFF: begin
          if (kind_q == bthalloc_pkg::K_FREE) st_q <= bthalloc_pkg::ST_OK;
          state <= S_FIN;
        end
        // grow the heap by a page
        S_G0: begin
          if (pages >= PGW'(MAX_PAGES) || tot == '0 || tot > (GW+1)'(GRAN_MAX)) begin
            grow_ok <= 1'b0;
            state   <= grow_ret;
          end else begin
            gt    <= tot;
            pages <= pages + PGW'(1);
            state <= S_G1;
          end
        end
        S_G1: begin
          if (merge) begin
            state <= S_G2;
          end else begin
            px       <= gt[GW-1:0];
            push_ret <= S_G2;
            state    <= S_P0;
          end
        end
        S_G2: begin
          rov     <= head;
          grow_ok <= 1'b1;
          state   <= grow_ret;
        end
        // push at list head
        S_P0: state <= S_P1;
        S_P1: begin
          head  <= {1'b0, px};
          state <= push_ret;
        end
        // unlink from list
        S_U0: state <= S_U1;
        S_U1: begin
          if (prv_rd == NIL) begin
            head <= nxt_rd;
            if (nxt_rd == NIL) rov <= NIL;
          end
          state <= unlink_ret;
        end
        // hand over the result
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            status         <= st_q;
            result_address <= (st_q == bthalloc_pkg::ST_OK) ? ra_q : '0;
            copy_length    <= cl_q;
            pages_in_use   <= pages;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the heap never shrinks
  a_pages_grow: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> pages >= $past(pages))
    else $error("page count decreased");

  // a failed request reports no address
  a_fail_addr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != bthalloc_pkg::ST_OK) |-> result_address == '0)
    else $error("address reported on failure");

  // an empty list leaves no roving pointer behind
  a_empty_rov: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && head == NIL) |-> rov == NIL)
    else $error("roving pointer set with empty free list");

  // a copy length only comes with success
  a_copy_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && copy_length != '0) |-> status == bthalloc_pkg::ST_OK)
    else $error("copy length on failed request");

endmodule
